// ----- hw/rtl/gnfsa_pkg.sv -----
// Package for the greedy nearest-free-slot assigner.
// Holds the request/response payload types, cell control types and constants.
// No dependencies.
`timescale 1ns / 1ps

package gnfsa_pkg;

   localparam int SLOT_DEPTH_DEF  = 64;
   localparam int VALUE_BITS_DEF  = 10;
   localparam int COUNT_BITS      = 7;
   localparam int ITEM_VALUE_BITS = 10;
   localparam int SLOT_FIELD_BITS = 6;
   localparam int COST_FIELD_BITS = 20;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_ASSIGN = 1'b1;

   typedef struct packed {
      logic                       kind;
      logic [SLOT_FIELD_BITS-1:0] slot_index;
      logic [ITEM_VALUE_BITS-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_BITS-1:0] chosen_slot;
      logic [COST_FIELD_BITS-1:0] cost;
      logic                       found;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic have;
   } scan_ctl_type;

   typedef struct packed {
      logic load;
      logic mark;
   } cell_cmd_type;

endpackage

// ----- hw/rtl/gnfsa_cell.sv -----
// One slot cell of the search chain: holds a slot value and its used mark,
// scores the passing search token and hands the best-so-far to its neighbor.
// Depends on gnfsa_pkg.
`timescale 1ns / 1ps

module gnfsa_cell #(
   parameter int SLOT_DEPTH = gnfsa_pkg::SLOT_DEPTH_DEF,
   parameter int VALUE_BITS = gnfsa_pkg::VALUE_BITS_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  gnfsa_pkg::cell_cmd_type                 cmd,
   input  logic [$clog2(SLOT_DEPTH)-1:0]           wr_idx,
   input  logic [VALUE_BITS-1:0]                   wr_value,
   input  logic [gnfsa_pkg::COUNT_BITS-1:0]        slot_count,
   input  gnfsa_pkg::scan_ctl_type                 in_ctl,
   input  logic [$clog2(SLOT_DEPTH)-1:0]           in_idx,
   input  logic [2*VALUE_BITS-1:0]                 in_cost,
   input  logic [VALUE_BITS-1:0]                   in_req,
   output gnfsa_pkg::scan_ctl_type                 out_ctl,
   output logic [$clog2(SLOT_DEPTH)-1:0]           out_idx,
   output logic [2*VALUE_BITS-1:0]                 out_cost,
   output logic [VALUE_BITS-1:0]                   out_req
);
   import gnfsa_pkg::*;

   localparam int INDEX_W = $clog2(SLOT_DEPTH);
   localparam int COST_W  = 2 * VALUE_BITS;
   localparam int CMP_W   = ((INDEX_W > COUNT_BITS) ? INDEX_W : COUNT_BITS) + 1;
   localparam logic [INDEX_W-1:0] CELL_IDX = INDEX_W'(CELL_INDEX);
   localparam logic [CMP_W-1:0]   CELL_POS = CMP_W'(CELL_INDEX);

   logic [VALUE_BITS-1:0] value_ff;
   logic                  used_ff;
   scan_ctl_type          ctl_ff, ctl_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;
   logic [COST_W-1:0]     cost_ff, cost_in;
   logic [VALUE_BITS-1:0] req_ff;

   logic [VALUE_BITS-1:0] diff;
   logic [COST_W-1:0]     sq;
   logic                  active;
   logic                  take;
   logic                  hit;

   always_comb begin
      diff   = (in_req >= value_ff) ? (in_req - value_ff) : (value_ff - in_req);
      sq     = COST_W'(diff) * COST_W'(diff);
      active = CELL_POS < CMP_W'(slot_count);
      take   = in_ctl.valid && active && !used_ff && (!in_ctl.have || (sq < in_cost));
      ctl_in.valid = in_ctl.valid;
      ctl_in.have  = in_ctl.have | take;
      idx_in  = take ? CELL_IDX : in_idx;
      cost_in = take ? sq : in_cost;
      hit     = wr_idx == CELL_IDX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         used_ff <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
         if (cmd.load && hit) begin
            used_ff <= 1'b0;
         end else if (cmd.mark && hit) begin
            used_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cost_ff <= cost_in;
      req_ff  <= in_req;
      if (cmd.load && hit) begin
         value_ff <= wr_value;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_idx  = idx_ff;
   assign out_cost = cost_ff;
   assign out_req  = req_ff;

endmodule

// ----- hw/rtl/greedy_nearest_free_slot_assign_top.sv -----
// Greedy nearest-free-slot assigner: top level with request/response buffering
// and the chain of slot cells. Depends on gnfsa_pkg and gnfsa_cell.
//
// Usage:
//  - Request channel (req_valid/req_stall/req_data): kind selects a load, which
//    writes item_value into slot slot_index and frees it, or an assign, which
//    searches the free slots below slot_count for the smallest squared
//    difference to item_value (lowest index wins a tie) and marks it used.
//  - Response channel (rsp_valid/rsp_stall/rsp_data): one response per assign,
//    none per load; found is low with zero index and cost when no slot is free.
//  - csr_wr_en/csr_wr_data write slot_count; change it only while idle.
//  - A load writes its slot when it is accepted. An assign walks a token through
//    all SLOT_DEPTH cells, one cell per cycle, and no new request is taken while
//    it is in flight; the response is registered when the token leaves the last
//    cell, and the next request can be taken in the same cycle it becomes valid.
//  - A finished response waits in a one-entry holding register while the
//    receiver stalls; further requests stall until it has moved on.
//  - Reset clears all used marks and sets slot_count to 64; slot values are
//    undefined until loaded.
`timescale 1ns / 1ps

module greedy_nearest_free_slot_assign_top #(
   parameter int SLOT_DEPTH = gnfsa_pkg::SLOT_DEPTH_DEF,
   parameter int VALUE_BITS = gnfsa_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gnfsa_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gnfsa_pkg::rsp_type                rsp_data,
   input  logic                              csr_wr_en,
   input  logic [gnfsa_pkg::COUNT_BITS-1:0]  csr_wr_data
);
   import gnfsa_pkg::*;

   localparam int INDEX_W  = $clog2(SLOT_DEPTH);
   localparam int COST_W   = 2 * VALUE_BITS;
   localparam int IDX_WIDE = ((INDEX_W > SLOT_FIELD_BITS) ? INDEX_W : SLOT_FIELD_BITS) + 1;
   localparam int VAL_WIDE = ((VALUE_BITS > ITEM_VALUE_BITS) ? VALUE_BITS : ITEM_VALUE_BITS) + 1;
   localparam int COST_WIDE = ((COST_W > COST_FIELD_BITS) ? COST_W : COST_FIELD_BITS) + 1;

   logic [COUNT_BITS-1:0] slot_count_ff;
   logic                  busy_ff, busy_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_type               pend_data_ff, pend_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   scan_ctl_type          chain_ctl  [SLOT_DEPTH+1];
   logic [INDEX_W-1:0]    chain_idx  [SLOT_DEPTH+1];
   logic [COST_W-1:0]     chain_cost [SLOT_DEPTH+1];
   logic [VALUE_BITS-1:0] chain_req  [SLOT_DEPTH+1];
   logic [SLOT_DEPTH-1:0] token_live;

   logic                  accept;
   logic                  exit_scan;
   logic [IDX_WIDE-1:0]   load_idx_wide;
   logic                  load_in_range;
   logic [VAL_WIDE-1:0]   value_wide;
   logic [VALUE_BITS-1:0] value_cut;
   logic [IDX_WIDE-1:0]   best_idx_wide;
   logic [COST_WIDE-1:0]  best_cost_wide;
   rsp_type               exit_rsp;
   cell_cmd_type          cmd;
   logic [INDEX_W-1:0]    wr_idx;

   assign req_stall = busy_ff | pend_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign exit_scan = chain_ctl[SLOT_DEPTH].valid;

   always_comb begin
      load_idx_wide  = IDX_WIDE'(req_data.slot_index);
      load_in_range  = load_idx_wide < IDX_WIDE'(SLOT_DEPTH);
      value_wide     = VAL_WIDE'(req_data.item_value);
      value_cut      = value_wide[VALUE_BITS-1:0];
      best_idx_wide  = IDX_WIDE'(chain_idx[SLOT_DEPTH]);
      best_cost_wide = COST_WIDE'(chain_cost[SLOT_DEPTH]);
      exit_rsp.found       = chain_ctl[SLOT_DEPTH].have;
      exit_rsp.chosen_slot = best_idx_wide[SLOT_FIELD_BITS-1:0];
      exit_rsp.cost        = best_cost_wide[COST_FIELD_BITS-1:0];
      cmd.load = accept && (req_data.kind == KIND_LOAD) && load_in_range;
      cmd.mark = exit_scan && chain_ctl[SLOT_DEPTH].have;
      wr_idx   = cmd.mark ? chain_idx[SLOT_DEPTH] : load_idx_wide[INDEX_W-1:0];
   end

   // Inject the search token at the head of the chain
   assign chain_ctl[0]  = '{valid: accept && (req_data.kind == KIND_ASSIGN), have: 1'b0};
   assign chain_idx[0]  = '0;
   assign chain_cost[0] = '0;
   assign chain_req[0]  = value_cut;

   for (genvar i = 0; i < SLOT_DEPTH; i++) begin : g_cell
      gnfsa_cell #(
         .SLOT_DEPTH (SLOT_DEPTH),
         .VALUE_BITS (VALUE_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .wr_idx     (wr_idx),
         .wr_value   (value_cut),
         .slot_count (slot_count_ff),
         .in_ctl     (chain_ctl[i]),
         .in_idx     (chain_idx[i]),
         .in_cost    (chain_cost[i]),
         .in_req     (chain_req[i]),
         .out_ctl    (chain_ctl[i+1]),
         .out_idx    (chain_idx[i+1]),
         .out_cost   (chain_cost[i+1]),
         .out_req    (chain_req[i+1])
      );
      assign token_live[i] = chain_ctl[i+1].valid;
   end

   always_comb begin
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      if (accept && (req_data.kind == KIND_ASSIGN)) begin
         busy_in = 1'b1;
      end
      if (exit_scan) begin
         busy_in = 1'b0;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_valid_ff && !rsp_valid_in) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
      end
      if (exit_scan) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = exit_rsp;
         end else begin
            pend_valid_in = 1'b1;
            pend_data_in  = exit_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= COUNT_RESET;
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slot_count_ff <= csr_wr_data;
         end
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_live))
      else $error("more than one search token in the chain");

   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      exit_scan |-> busy_ff && !pend_valid_ff)
      else $error("search token left the chain while idle or holding");

   a_assign_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == KIND_ASSIGN) |=> busy_ff)
      else $error("assign request did not start a search");

   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |->
         (rsp_data_ff.cost == '0) && (rsp_data_ff.chosen_slot == '0))
      else $error("empty response carries a slot or cost");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for greedy_nearest_free_slot_assign_top.
// Drives loads and assigns, predicts each response from a shadow slot table or takes it from the directed plan.
// Depends on gnfsa_pkg and the top-level RTL.
`timescale 1ns / 1ps

module testbench;
   import gnfsa_pkg::*;

   localparam int SLOTS       = SLOT_DEPTH_DEF;
   localparam int DRAIN_WAIT  = SLOT_DEPTH_DEF + 8;
   localparam int STUCK_LIMIT = 5000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 125;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_ASSIGN,
      ROW_COUNT
   } row_op_type;

   typedef struct packed {
      row_op_type                 op;
      logic [SLOT_FIELD_BITS-1:0] idx;
      logic [ITEM_VALUE_BITS-1:0] value;
      logic                       typed;
      rsp_type                    want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;

   logic [ITEM_VALUE_BITS-1:0] shadow_value [SLOTS];
   logic                       shadow_taken [SLOTS];
   logic [COUNT_BITS-1:0]      shadow_count = COUNT_RESET;
   rsp_type                    pending_assigns [$];
   rsp_type                    oldest_assign;
   bit                         allow_idle = 1'b1;
   int unsigned                mismatch_count = 0;
   int unsigned                stuck_cycles = 0;

   plan_row_type directed_plan [24] = '{
      '{ROW_ASSIGN, 6'd0,  10'd0,    1'b1, '{6'd0,  20'd0,       1'b1}},
      '{ROW_ASSIGN, 6'd0,  10'd0,    1'b1, '{6'd1,  20'd256,     1'b1}},
      '{ROW_ASSIGN, 6'd0,  10'd1023, 1'b1, '{6'd63, 20'd225,     1'b1}},
      '{ROW_LOAD,   6'd63, 10'd1023, 1'b0, '0},
      '{ROW_ASSIGN, 6'd63, 10'd1023, 1'b1, '{6'd63, 20'd0,       1'b1}},
      '{ROW_COUNT,  6'd0,  10'd1,    1'b0, '0},
      '{ROW_ASSIGN, 6'd0,  10'd512,  1'b1, '{6'd0,  20'd0,       1'b0}},
      '{ROW_LOAD,   6'd0,  10'd0,    1'b0, '0},
      '{ROW_ASSIGN, 6'd0,  10'd1023, 1'b1, '{6'd0,  20'd1046529, 1'b1}},
      '{ROW_COUNT,  6'd0,  10'd0,    1'b0, '0},
      '{ROW_ASSIGN, 6'd0,  10'd1023, 1'b1, '{6'd0,  20'd0,       1'b0}},
      '{ROW_COUNT,  6'd0,  10'd3,    1'b0, '0},
      '{ROW_LOAD,   6'd0,  10'd100,  1'b0, '0},
      '{ROW_LOAD,   6'd1,  10'd140,  1'b0, '0},
      '{ROW_ASSIGN, 6'd0,  10'd120,  1'b0, '0},
      '{ROW_ASSIGN, 6'd0,  10'd120,  1'b0, '0},
      '{ROW_ASSIGN, 6'd0,  10'd120,  1'b0, '0},
      '{ROW_ASSIGN, 6'd0,  10'd120,  1'b1, '{6'd0,  20'd0,       1'b0}},
      '{ROW_COUNT,  6'd0,  10'd127,  1'b0, '0},
      '{ROW_LOAD,   6'd42, 10'd682,  1'b0, '0},
      '{ROW_LOAD,   6'd21, 10'd341,  1'b0, '0},
      '{ROW_ASSIGN, 6'd21, 10'd682,  1'b0, '0},
      '{ROW_ASSIGN, 6'd42, 10'd341,  1'b0, '0},
      '{ROW_COUNT,  6'd0,  10'd64,   1'b0, '0}
   };

   greedy_nearest_free_slot_assign_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type nearest_free_slot(input logic [ITEM_VALUE_BITS-1:0] want);
      rsp_type res;
      int      best_cost;
      int      limit;
      int      diff;
      int      i;
      res = '0;
      best_cost = -1;
      limit = (int'(shadow_count) > SLOTS) ? SLOTS : int'(shadow_count);
      for (i = 0; i < limit; i++) begin
         if (!shadow_taken[i]) begin
            diff = int'(want) - int'(shadow_value[i]);
            if (best_cost < 0 || diff * diff < best_cost) begin
               best_cost = diff * diff;
               res.chosen_slot = i[SLOT_FIELD_BITS-1:0];
            end
         end
      end
      if (best_cost >= 0) begin
         res.cost = best_cost[COST_FIELD_BITS-1:0];
         res.found = 1'b1;
         shadow_taken[res.chosen_slot] = 1'b1;
      end
      return res;
   endfunction

   // hold valid until the block takes the request
   task automatic push_request(input req_type item);
      while (allow_idle && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic issue_request(input req_type item, input logic typed, input rsp_type want);
      rsp_type predicted;
      push_request(item);
      if (item.kind == KIND_ASSIGN) begin
         predicted = nearest_free_slot(item.item_value);
         pending_assigns.push_back(typed ? want : predicted);
      end else begin
         shadow_value[item.slot_index] = item.item_value;
         shadow_taken[item.slot_index] = 1'b0;
      end
   endtask

   // drain, let a trailing load settle, then write
   task automatic write_slot_count(input logic [COUNT_BITS-1:0] count);
      req_valid <= 1'b0;
      while (pending_assigns.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_count = count;
   endtask

   always @(posedge clock) begin
      rsp_stall <= allow_idle && ($urandom_range(0, 99) < 23);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_assigns.size() == 0) begin
            $error("unexpected response: chosen_slot %0d cost %0d found %0d",
                   rsp_data.chosen_slot, rsp_data.cost, rsp_data.found);
            mismatch_count++;
         end else begin
            oldest_assign = pending_assigns.pop_front();
            if (rsp_data.chosen_slot !== oldest_assign.chosen_slot) begin
               $error("chosen_slot: expected %0d, actual %0d",
                      oldest_assign.chosen_slot, rsp_data.chosen_slot);
               mismatch_count++;
            end
            if (rsp_data.cost !== oldest_assign.cost) begin
               $error("cost: expected %0d, actual %0d", oldest_assign.cost, rsp_data.cost);
               mismatch_count++;
            end
            if (rsp_data.found !== oldest_assign.found) begin
               $error("found: expected %0d, actual %0d", oldest_assign.found, rsp_data.found);
               mismatch_count++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      req_type               item;
      logic [COUNT_BITS-1:0] phase_count;
      int                    load_pct;
      int                    phase;
      int                    n;
      int                    r;

      foreach (shadow_taken[s]) shadow_taken[s] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot so no request reads an unloaded value
      for (n = 0; n < SLOTS; n++) begin
         item.kind = KIND_LOAD;
         item.slot_index = n[SLOT_FIELD_BITS-1:0];
         item.item_value = ITEM_VALUE_BITS'(n * 16);
         issue_request(item, 1'b0, '0);
      end

      for (r = 0; r < $size(directed_plan); r++) begin
         if (directed_plan[r].op == ROW_COUNT) begin
            write_slot_count(directed_plan[r].value[COUNT_BITS-1:0]);
         end else begin
            item.kind = (directed_plan[r].op == ROW_ASSIGN) ? KIND_ASSIGN : KIND_LOAD;
            item.slot_index = directed_plan[r].idx;
            item.item_value = directed_plan[r].value;
            issue_request(item, directed_plan[r].typed, directed_plan[r].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: phase_count = 7'd64;
            1: phase_count = 7'd2;
            2: phase_count = 7'd127;
            3: phase_count = 7'd1;
            4: phase_count = 7'($urandom_range(3, 63));
            5: phase_count = 7'd0;
            7: phase_count = 7'($urandom_range(0, 127));
            8: phase_count = 7'd96;
            default: phase_count = 7'd64;
         endcase
         write_slot_count(phase_count);
         allow_idle = (phase != 6);
         load_pct = $urandom_range(25, 65);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            item.slot_index = SLOT_FIELD_BITS'($urandom_range(0, 63));
            if ($urandom_range(0, 99) < load_pct) begin
               item.kind = KIND_LOAD;
               item.item_value = $urandom_range(0, 1) ? ITEM_VALUE_BITS'($urandom_range(0, 1023))
                                                      : ITEM_VALUE_BITS'($urandom_range(0, 15) * 64);
            end else begin
               item.kind = KIND_ASSIGN;
               item.item_value = ($urandom_range(0, 3) == 0)
                                 ? ITEM_VALUE_BITS'($urandom_range(0, 15) * 64 + 32)
                                 : ITEM_VALUE_BITS'($urandom_range(0, 1023));
            end
            issue_request(item, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_assigns.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
